// File: hdl/srgb_to_xyz_converter_assert.svh
// Assertion macros for the sRGB to XYZ converter RTL.
`ifndef SRGB_TO_XYZ_CONVERTER_ASSERT_SVH
`define SRGB_TO_XYZ_CONVERTER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define S2X_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define S2X_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/s2x_pkg.sv
// Shared constants, types and elaboration-time table functions for the converter.
package s2x_pkg;

  localparam int unsigned LINEAR_FRAC_BITS = 16;
  localparam int unsigned COEF_FRAC_BITS   = 20;
  localparam int unsigned CHAN_W           = 8;
  localparam int unsigned OUT_W            = 7;
  localparam int unsigned CURVE_DEPTH      = 1 << CHAN_W;
  localparam int unsigned LIN_W            = OUT_W + LINEAR_FRAC_BITS;
  localparam int unsigned COEF_W           = COEF_FRAC_BITS;
  localparam int unsigned PROD_W           = LIN_W + COEF_W;
  localparam int unsigned SUM_W            = PROD_W + 2;
  localparam int unsigned RESULT_LSB       = COEF_FRAC_BITS + LINEAR_FRAC_BITS;
  localparam int unsigned NUM_ROWS         = 3;

  // Exact-check width for y^5 * d^12 against 1e10 * 2^(5F) * n^12.
  localparam int unsigned BIG_W            = 448;
  localparam logic [63:0] CURVE_DEN        = 64'd269025;
  localparam logic [63:0] CURVE_LIMIT      = 64'd100 << LINEAR_FRAC_BITS;

  localparam logic [OUT_W-1:0] X_MAX = OUT_W'(95);
  localparam logic [OUT_W-1:0] Y_MAX = OUT_W'(100);
  localparam logic [OUT_W-1:0] Z_MAX = OUT_W'(108);

  typedef logic [NUM_ROWS-1:0][COEF_W-1:0] coef_col_t;
  typedef logic [NUM_ROWS-1:0][PROD_W-1:0] prod_col_t;

  // Coefficient in millionths, rounded to nearest with 20 fraction bits.
  function automatic logic [COEF_W-1:0] coef(input logic [31:0] micro);
    logic [63:0] scaled;
    scaled = (64'(micro) * 64'd1048576 + 64'd500000) / 64'd1000000;
    return COEF_W'(scaled);
  endfunction

  // Row order inside a column: index 0 = X, 1 = Y, 2 = Z.
  localparam coef_col_t COEF_RED   = {coef(32'd19334),  coef(32'd212671), coef(32'd412453)};
  localparam coef_col_t COEF_GREEN = {coef(32'd119193), coef(32'd715160), coef(32'd357580)};
  localparam coef_col_t COEF_BLUE  = {coef(32'd950227), coef(32'd72169),  coef(32'd180423)};

  // True when y <= 100 * 2^F * (n / 269025)^2.4, checked exactly in wide integers.
  function automatic bit curve_fits(input logic [63:0] y, input logic [31:0] n);
    logic [BIG_W-1:0] lhs;
    logic [BIG_W-1:0] rhs;
    lhs = BIG_W'(1);
    for (int i = 0; i < 5; i++) lhs = lhs * BIG_W'(y);
    for (int i = 0; i < 12; i++) lhs = lhs * BIG_W'(CURVE_DEN);
    rhs = BIG_W'(64'd10000000000) << (5 * LINEAR_FRAC_BITS);
    for (int i = 0; i < 12; i++) rhs = rhs * BIG_W'(n);
    return (lhs <= rhs);
  endfunction

  // Linear value times 100 for one 8-bit code, truncated, F fraction bits.
  function automatic logic [LIN_W-1:0] curve_entry(input int unsigned c);
    logic [63:0] lin;
    logic [31:0] n;
    real         v;
    logic [63:0] y;
    if (c <= 10) begin
      lin = ((64'(c) * 64'd10000) << LINEAR_FRAC_BITS) / 64'd329460;
      return LIN_W'(lin);
    end
    n = 32'(1000 * c + 14025);
    v = 100.0 * real'(64'd1 << LINEAR_FRAC_BITS) * $pow(real'(n) / 269025.0, 2.4);
    y = 64'($rtoi(v));
    if (y > CURVE_LIMIT) y = CURVE_LIMIT;
    // float estimate is within a unit or so; settle it exactly
    for (int i = 0; i < 3; i++) begin
      if (y < CURVE_LIMIT && curve_fits(y + 64'd1, n)) y = y + 64'd1;
    end
    for (int i = 0; i < 3; i++) begin
      if (y != 64'd0 && !curve_fits(y, n)) y = y - 64'd1;
    end
    return LIN_W'(y);
  endfunction

endpackage

// File: hdl/s2x_stream_if.sv
// Stream interfaces for the pixel input and the XYZ result.
interface s2x_pixel_if
  import s2x_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface s2x_xyz_if
  import s2x_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] x_value;
  logic [OUT_W-1:0] y_value;
  logic [OUT_W-1:0] z_value;

  modport source (output valid, output x_value, output y_value, output z_value, input ready);
  modport sink   (input valid, input x_value, input y_value, input z_value, output ready);
endinterface

// File: hdl/srgb_to_xyz_converter.sv
// sRGB (8-bit per channel) to CIE XYZ D65 converter, whole numbers, white at Y = 100.
// Fully pipelined: while the output is not stalled, one pixel request is taken every
// clock and one XYZ result leaves every clock. An accepted request passes through these
// stages: curve lookup, per-lane coefficient multiply, row sum in the output register.
// The whole pipeline advances together; while a result sits unread at the output the
// pipeline holds and pixel_i.ready is low in that same cycle. Empty stages do not
// collapse, so a stall costs every stage. The transfer curve is a 256-entry constant
// table built at elaboration, with no memory and no start-up pass.
module srgb_to_xyz_converter
  import s2x_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  s2x_pixel_if.sink pixel_i,
  s2x_xyz_if.source xyz_o
);

  `include "srgb_to_xyz_converter_assert.svh"

  logic      en;
  logic      v1_q;
  logic      v2_q;
  logic      v3_q;
  prod_col_t red_prod;
  prod_col_t green_prod;
  prod_col_t blue_prod;

  assign en            = !v3_q || xyz_o.ready;
  assign pixel_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= pixel_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  s2x_lane u_lane_red (
    .clk_i  (clk_i),
    .en_i   (en),
    .code_i (pixel_i.red),
    .coef_i (COEF_RED),
    .prod_o (red_prod)
  );

  s2x_lane u_lane_green (
    .clk_i  (clk_i),
    .en_i   (en),
    .code_i (pixel_i.green),
    .coef_i (COEF_GREEN),
    .prod_o (green_prod)
  );

  s2x_lane u_lane_blue (
    .clk_i  (clk_i),
    .en_i   (en),
    .code_i (pixel_i.blue),
    .coef_i (COEF_BLUE),
    .prod_o (blue_prod)
  );

  s2x_merge u_merge (
    .clk_i     (clk_i),
    .en_i      (en),
    .red_i     (red_prod),
    .green_i   (green_prod),
    .blue_i    (blue_prod),
    .x_value_o (xyz_o.x_value),
    .y_value_o (xyz_o.y_value),
    .z_value_o (xyz_o.z_value)
  );

  assign xyz_o.valid = v3_q;

  `S2X_ASSERT_NOW(a_stall_blocks_input, clk_i, rst_ni,
                  xyz_o.valid && !xyz_o.ready, !pixel_i.ready, "input taken during stall")
  `S2X_ASSERT_NEXT(a_request_enters, clk_i, rst_ni,
                   pixel_i.valid && pixel_i.ready, v1_q, "accepted request lost")
  `S2X_ASSERT_NEXT(a_stage_reaches_out, clk_i, rst_ni,
                   en && v2_q, xyz_o.valid, "result did not reach output")
  `S2X_ASSERT_NOW(a_result_range, clk_i, rst_ni, xyz_o.valid,
                  xyz_o.x_value <= X_MAX && xyz_o.y_value <= Y_MAX && xyz_o.z_value <= Z_MAX,
                  "XYZ result out of range")

endmodule

// File: hdl/s2x_lane.sv
// One channel lane: transfer-curve lookup, then products with its matrix column.
module s2x_lane
  import s2x_pkg::*;
(
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [CHAN_W-1:0] code_i,
  input  coef_col_t         coef_i,
  output prod_col_t         prod_o
);

  logic [LIN_W-1:0] curve_w [CURVE_DEPTH];
  logic [LIN_W-1:0] lin_q;
  logic [LIN_W-1:0] lin_d;
  prod_col_t        prod_q;
  prod_col_t        prod_d;

  for (genvar k = 0; k < CURVE_DEPTH; k++) begin : g_curve
    localparam logic [LIN_W-1:0] Entry = curve_entry(k);
    assign curve_w[k] = Entry;
  end

  assign lin_d = curve_w[code_i];

  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      prod_d[r] = PROD_W'(lin_q) * PROD_W'(coef_i[r]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lin_q  <= lin_d;
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

// File: hdl/s2x_merge.sv
// Merge stage: sums the three lane products per row and keeps the integer part.
module s2x_merge
  import s2x_pkg::*;
(
  input  logic             clk_i,
  input  logic             en_i,
  input  prod_col_t        red_i,
  input  prod_col_t        green_i,
  input  prod_col_t        blue_i,
  output logic [OUT_W-1:0] x_value_o,
  output logic [OUT_W-1:0] y_value_o,
  output logic [OUT_W-1:0] z_value_o
);

  logic [NUM_ROWS-1:0][SUM_W-1:0] sum_w;
  logic [NUM_ROWS-1:0][OUT_W-1:0] res_d;
  logic [NUM_ROWS-1:0][OUT_W-1:0] res_q;

  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      sum_w[r] = SUM_W'(red_i[r]) + SUM_W'(green_i[r]) + SUM_W'(blue_i[r]);
      res_d[r] = sum_w[r][RESULT_LSB +: OUT_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign x_value_o = res_q[0];
  assign y_value_o = res_q[1];
  assign z_value_o = res_q[2];

endmodule

// File: tb/tb_srgb_to_xyz_converter.sv
// Self-checking testbench for srgb_to_xyz_converter: directed and random stream traffic against a local predictor.
module tb_srgb_to_xyz_converter
  import s2x_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_PIXELS = 1930;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned IDLE_PCT      = 21;
  localparam int unsigned CALM_FIRST    = 700;   // no idling or stalls in this item window
  localparam int unsigned CALM_LAST     = 1000;
  localparam int unsigned TAIL_CYCLES   = 16;
  localparam int unsigned BIG_BITS      = 384;

  // D65 matrix in millionths, row-major: X, Y, Z rows; red, green, blue columns
  localparam int unsigned D65_MICRO [9] = '{412453, 357580, 180423,
                                            212671, 715160,  72169,
                                             19334, 119193, 950227};

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    bit                pause;  // sender holds until all results are back
  } pixel_req_t;

  typedef struct packed {
    logic [OUT_W-1:0] x;
    logic [OUT_W-1:0] y;
    logic [OUT_W-1:0] z;
  } xyz_t;

  logic clk_i;
  logic rst_ni;

  s2x_pixel_if pix ();
  s2x_xyz_if   xyz ();

  srgb_to_xyz_converter uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pixel_i (pix),
    .xyz_o   (xyz)
  );

  logic [LIN_W-1:0]  lin_lut [CURVE_DEPTH];
  longint unsigned   mix_coef [3][3];
  logic [BIG_BITS-1:0] den_pow12;

  pixel_req_t pending_q [$];
  xyz_t       xyz_expected_q [$];
  xyz_t       xyz_want;

  int unsigned queued_cnt   = 0;
  int unsigned sent_cnt     = 0;
  int unsigned accepted_cnt = 0;
  int unsigned seen_cnt     = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned cyc_cnt      = 0;

  // y^5 * 269025^12 <= 1e10 * 2^(5F) * n^12, i.e. y <= 100 * 2^F * (n/269025)^2.4
  function automatic bit power_fits(longint unsigned y, int unsigned n);
    logic [BIG_BITS-1:0] lhs;
    logic [BIG_BITS-1:0] rhs;
    lhs = den_pow12;
    repeat (5) lhs = lhs * BIG_BITS'(y);
    rhs = BIG_BITS'(64'd10000000000) << (5 * LINEAR_FRAC_BITS);
    repeat (12) rhs = rhs * BIG_BITS'(n);
    return lhs <= rhs;
  endfunction

  // Linear light times 100, truncated, LINEAR_FRAC_BITS fraction bits
  function automatic logic [LIN_W-1:0] linearize(int unsigned c);
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    int unsigned     n;
    if (c <= 10) begin
      return LIN_W'(((64'(c) * 64'd10000) << LINEAR_FRAC_BITS) / 64'd329460);
    end
    // (c/255 + 0.055)/1.055 == (1000c + 14025) / 269025
    n  = 1000 * c + 14025;
    lo = 0;
    hi = longint'(100) << LINEAR_FRAC_BITS;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      if (power_fits(mid, n)) lo = mid;
      else hi = mid - 1;
    end
    return LIN_W'(lo);
  endfunction

  function automatic xyz_t convert_pixel(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                                         logic [CHAN_W-1:0] b);
    longint unsigned lin [3];
    longint unsigned acc;
    logic [OUT_W-1:0] row_val [3];
    xyz_t res;
    lin[0] = lin_lut[r];
    lin[1] = lin_lut[g];
    lin[2] = lin_lut[b];
    for (int row = 0; row < 3; row++) begin
      acc = 0;
      for (int k = 0; k < 3; k++) acc += mix_coef[row][k] * lin[k];
      row_val[row] = OUT_W'(acc >> (COEF_FRAC_BITS + LINEAR_FRAC_BITS));
    end
    res.x = row_val[0];
    res.y = row_val[1];
    res.z = row_val[2];
    return res;
  endfunction

  function automatic bit take_break(int unsigned cnt);
    if (cnt >= CALM_FIRST && cnt < CALM_LAST) return 1'b0;
    return $urandom_range(99) < IDLE_PCT;
  endfunction

  // Biased toward both ends of the code range and the linear-segment boundary
  function automatic logic [CHAN_W-1:0] rand_chan();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 12) return CHAN_W'($urandom_range(12));
    if (pick < 24) return CHAN_W'($urandom_range(255, 243));
    return CHAN_W'($urandom_range(255));
  endfunction

  task automatic add_pixel(int unsigned r, int unsigned g, int unsigned b);
    pending_q.push_back('{red: CHAN_W'(r), green: CHAN_W'(g), blue: CHAN_W'(b), pause: 1'b0});
    queued_cnt++;
  endtask

  task automatic add_pause();
    pending_q.push_back('{red: '0, green: '0, blue: '0, pause: 1'b1});
  endtask

  task automatic report_mismatch(string msg);
    mismatch_cnt++;
    $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cyc_cnt++;
    if (cyc_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cyc_cnt);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Pixel driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix.valid <= 1'b0;
      pix.red   <= '0;
      pix.green <= '0;
      pix.blue  <= '0;
    end else begin
      if (pix.valid && pix.ready) begin
        xyz_expected_q.push_back(convert_pixel(pix.red, pix.green, pix.blue));
        accepted_cnt++;
      end
      if (!pix.valid || pix.ready) begin
        if (pending_q.size() != 0 && pending_q[0].pause) begin
          if (xyz_expected_q.size() == 0) void'(pending_q.pop_front());
          pix.valid <= 1'b0;
        end else if (pending_q.size() != 0 && !take_break(sent_cnt)) begin
          pix.red   <= pending_q[0].red;
          pix.green <= pending_q[0].green;
          pix.blue  <= pending_q[0].blue;
          pix.valid <= 1'b1;
          void'(pending_q.pop_front());
          sent_cnt++;
        end else begin
          pix.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xyz.ready <= 1'b0;
    end else begin
      if (xyz.valid && xyz.ready) begin
        seen_cnt++;
        if (xyz_expected_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result x=%0d y=%0d z=%0d",
                                    xyz.x_value, xyz.y_value, xyz.z_value));
        end else begin
          xyz_want = xyz_expected_q.pop_front();
          if (xyz.x_value !== xyz_want.x)
            report_mismatch($sformatf("result %0d: x=%0d, want %0d",
                                      seen_cnt, xyz.x_value, xyz_want.x));
          if (xyz.y_value !== xyz_want.y)
            report_mismatch($sformatf("result %0d: y=%0d, want %0d",
                                      seen_cnt, xyz.y_value, xyz_want.y));
          if (xyz.z_value !== xyz_want.z)
            report_mismatch($sformatf("result %0d: z=%0d, want %0d",
                                      seen_cnt, xyz.z_value, xyz_want.z));
        end
      end
      xyz.ready <= !take_break(seen_cnt);
    end
  end

  initial begin
    rst_ni    = 1'b0;
    pix.valid = 1'b0;
    pix.red   = '0;
    pix.green = '0;
    pix.blue  = '0;
    xyz.ready = 1'b0;

    den_pow12 = BIG_BITS'(1);
    repeat (12) den_pow12 = den_pow12 * BIG_BITS'(269025);
    for (int c = 0; c < CURVE_DEPTH; c++) lin_lut[c] = linearize(c);
    for (int i = 0; i < 9; i++)
      mix_coef[i / 3][i % 3] = (longint'(D65_MICRO[i]) * 1048576 + 500000) / 1000000;

    // directed: black, white, primaries, secondaries, linear/power boundary, greys and mixed codes
    add_pixel(0, 0, 0);
    add_pixel(255, 255, 255);
    add_pixel(255, 0, 0);
    add_pixel(0, 255, 0);
    add_pixel(0, 0, 255);
    add_pixel(255, 255, 0);
    add_pixel(0, 255, 255);
    add_pixel(255, 0, 255);
    add_pixel(1, 1, 1);
    add_pixel(10, 10, 10);
    add_pixel(11, 11, 11);
    add_pixel(10, 11, 12);
    add_pixel(12, 11, 10);
    add_pixel(128, 128, 128);
    add_pixel(170, 85, 170);
    add_pixel(85, 170, 85);
    add_pixel(254, 254, 254);
    add_pixel(1, 254, 127);
    add_pixel(128, 64, 32);
    add_pixel(3, 200, 9);
    add_pause();

    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      if (i == RANDOM_PIXELS / 2) add_pause();
      add_pixel(rand_chan(), rand_chan(), rand_chan());
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_q.size() != 0) @(posedge clk_i);
    while (accepted_cnt != queued_cnt || xyz_expected_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
